### design/frlm_pkg.sv
// ----------------------------------------------------------------------------
// frlm_pkg
// Shared widths, register codes and limits of the frame rate limiter and
// meter.
// ----------------------------------------------------------------------------
package frlm_pkg;

  localparam int TIME_W    = 32;  // millisecond timestamps
  localparam int BYTE_W    = 8;   // config registers, wait, frame counter
  localparam int RATE_W    = 25;  // Q.8 rate
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = TIME_W + BYTE_W;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_FPS  = 2'd0,
    CFG_MAX_WAIT_MS = 2'd1,
    CFG_MEAS_PERIOD = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] TARGET_FPS_RST  = 8'd60;
  localparam logic [BYTE_W-1:0] MAX_WAIT_MS_RST = 8'd17;
  localparam logic [BYTE_W-1:0] MEAS_PERIOD_RST = 8'd60;

endpackage

### design/frame_rate_limiter_meter_core.sv
// ----------------------------------------------------------------------------
// frame_rate_limiter_meter_core
// Frame pacing and rate meter over a ring of the last DEPTH frame stamps.
// Input channel (in_valid/in_stall): in_mode 0 queries the wait time for
// in_now_ms, in_mode 1 records in_now_ms as a frame timestamp. Every item
// gives exactly one result on the output channel (out_valid/out_stall):
// out_wait_ms, out_rate_q8 (last measured rate, Q.8) and out_window_full.
// Registers target_fps, max_wait_ms and the measurement period are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Path from accept to out_valid: a plain record or a query on an empty ring
// goes straight to the result; a measuring record reads the oldest stamp and
// divides unless the span is zero; a query reads it, multiplies, compares,
// divides only under budget with nonzero target_fps. The shared iterative
// divider is DIV_W wide (25 at DEPTH=120), one quotient bit per cycle. One
// item is in work at a time; the next is accepted in the cycle after its
// result is loaded. A result held by out_stall stays in the output register
// while the next item is worked on; that item waits to complete until the register frees.
// Reset clears the pointers, fill count, frame counter and rate and restores
// the register defaults; the ring is not cleared, only written entries are read.
// ----------------------------------------------------------------------------
module frame_rate_limiter_meter_core
  import frlm_pkg::*;
#(
  parameter int DEPTH = 120
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_wait_ms,
  output logic [RATE_W-1:0]    out_rate_q8,
  output logic                 out_window_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int          PTR_W    = $clog2(DEPTH);
  localparam int          CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned RATE_NUM = 1000 * (DEPTH - 1) * 256;
  localparam int          NUM_W    = $clog2(RATE_NUM + 1);
  localparam int          BUD_W    = $clog2(1000 * DEPTH + 1);
  localparam int          DIV_W    = (NUM_W > BUD_W) ? NUM_W : BUD_W;
  localparam int          CMP_W    = DIV_W + RATE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_CMP,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r;
  logic              is_query_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [MUL_W-1:0]  used_r;
  logic [BYTE_W-1:0] res_wait_r;

  logic [PTR_W-1:0]  write_ptr_r;
  logic [PTR_W-1:0]  oldest_ptr_r;
  logic [CNT_W-1:0]  fill_r;
  logic [BYTE_W-1:0] frame_cnt_r;
  logic [RATE_W-1:0] rate_r;

  logic [BYTE_W-1:0] target_fps_r;
  logic [BYTE_W-1:0] max_wait_r;
  logic [BYTE_W-1:0] interval_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_wait_r;
  logic [RATE_W-1:0] out_rate_r;
  logic              out_full_r;

  logic              in_acc;
  logic              out_free;
  logic [PTR_W-1:0]  wp_next;
  logic              not_full;
  logic [CNT_W-1:0]  fill_new;
  logic [BYTE_W-1:0] cnt_inc;
  logic              cnt_match;
  logic              meas_go;

  logic              ring_we;
  logic              ring_re;
  logic [PTR_W-1:0]  ring_raddr;
  logic [TIME_W-1:0] ring_rdata;

  logic [TIME_W-1:0] span;
  logic [BUD_W-1:0]  budget;
  logic              over_budget;
  logic [BUD_W-1:0]  slack;

  logic              div_start;
  logic [DIV_W-1:0]  div_dvd;
  logic [TIME_W-1:0] div_dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic              rate_sat;
  logic              wait_clamp;

  // --------------------------------------------------------------------------
  // Handshakes and pointer arithmetic
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    wp_next   = (write_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : write_ptr_r + 1'b1;
    not_full  = (fill_r < CNT_W'(DEPTH));
    fill_new  = not_full ? fill_r + 1'b1 : fill_r;
    cnt_inc   = frame_cnt_r + 1'b1;
    cnt_match = (cnt_inc == interval_r);
    meas_go   = cnt_match && (fill_new == CNT_W'(DEPTH));
  end

  // --------------------------------------------------------------------------
  // Ring access: records write at the write pointer; the measurement reads
  // the oldest stamp, which after the write sits at the next write pointer.
  // --------------------------------------------------------------------------
  always_comb begin
    ring_we    = in_acc && in_mode;
    ring_re    = 1'b0;
    ring_raddr = oldest_ptr_r;
    if (in_acc) begin
      if (in_mode) begin
        ring_re    = meas_go;
        ring_raddr = wp_next;
      end else begin
        ring_re    = (fill_r != '0);
      end
    end
  end

  frlm_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_ptr_r),
    .wdata (in_now_ms),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath around the shared divider
  // --------------------------------------------------------------------------
  always_comb begin
    span        = now_r - ring_rdata;
    budget      = BUD_W'(fill_r) * BUD_W'(1000);
    over_budget = (used_r >= MUL_W'(budget));
    slack       = budget - BUD_W'(used_r);
    div_start   = 1'b0;
    if (state_r == S_LOAD && !is_query_r && span != '0) begin
      div_start = 1'b1;
    end
    if (state_r == S_CMP && target_fps_r != '0 && !over_budget) begin
      div_start = 1'b1;
    end
    div_dvd    = is_query_r ? DIV_W'(slack) : DIV_W'(RATE_NUM);
    div_dvs    = is_query_r ? TIME_W'(target_fps_r) : span;
    rate_sat   = ({{RATE_W{1'b0}}, div_q} > CMP_W'(RATE_MAX));
    wait_clamp = (div_q > DIV_W'(max_wait_r));
  end

  frlm_div #(
    .DVD_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_fps_r <= TARGET_FPS_RST;
      max_wait_r   <= MAX_WAIT_MS_RST;
      interval_r   <= MEAS_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_FPS:  target_fps_r <= cfg_data;
        CFG_MAX_WAIT_MS: max_wait_r   <= cfg_data;
        CFG_MEAS_PERIOD: interval_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, ring state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      is_query_r   <= 1'b0;
      write_ptr_r  <= '0;
      oldest_ptr_r <= '0;
      fill_r       <= '0;
      frame_cnt_r  <= '0;
      rate_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // a result loaded this cycle takes the place of the one leaving
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r      <= in_now_ms;
            is_query_r <= !in_mode;
            res_wait_r <= '0;
            if (in_mode) begin
              write_ptr_r <= wp_next;
              fill_r      <= fill_new;
              if (!not_full) begin
                oldest_ptr_r <= wp_next;
              end
              frame_cnt_r <= cnt_match ? '0 : cnt_inc;
              state_r     <= meas_go ? S_LOAD : S_DONE;
            end else begin
              state_r <= (fill_r != '0) ? S_LOAD : S_DONE;
            end
          end
        end
        S_LOAD: begin
          if (is_query_r) begin
            elapsed_r <= span;
            state_r   <= S_MUL;
          end else begin
            // zero span keeps the previous rate
            state_r <= (span != '0) ? S_DIV : S_DONE;
          end
        end
        S_MUL: begin
          used_r  <= MUL_W'(target_fps_r) * MUL_W'(elapsed_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (target_fps_r == '0) begin
            res_wait_r <= max_wait_r;
            state_r    <= S_DONE;
          end else if (over_budget) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (is_query_r) begin
              res_wait_r <= wait_clamp ? max_wait_r : div_q[BYTE_W-1:0];
            end else begin
              rate_r <= rate_sat ? RATE_MAX : RATE_W'(div_q);
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_wait_r  <= res_wait_r;
            out_rate_r  <= rate_r;
            out_full_r  <= (fill_r == CNT_W'(DEPTH));
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wait_ms     = out_wait_r;
  assign out_rate_q8     = out_rate_r;
  assign out_window_full = out_full_r;

endmodule

### design/frlm_ring.sv
// ----------------------------------------------------------------------------
// frlm_ring
// Timestamp ring storage: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module frlm_ring
  import frlm_pkg::*;
#(
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [TIME_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [TIME_W-1:0]        rdata
);

  logic [TIME_W-1:0] mem_r [DEPTH];
  logic [TIME_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/frlm_div.sv
// ----------------------------------------------------------------------------
// frlm_div
// Restoring radix-2 divider, one quotient bit per cycle. The divisor must be
// nonzero. The quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module frlm_div
  import frlm_pkg::*;
#(
  parameter int DVD_W = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [TIME_W-1:0] rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [TIME_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // partial remainder stays below the divisor, so 32 bits hold it
        rem_r <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
